>>> hdl/quality_filtered_kmer_windows_unit_assert.svh
// Assertion macros shared by the RTL of the k-mer window unit.
// Each macro checks a property on the rising clock edge, disabled while reset is low.
`ifndef QUALITY_FILTERED_KMER_WINDOWS_UNIT_ASSERT_SVH
`define QUALITY_FILTERED_KMER_WINDOWS_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QFKW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QFKW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/qfkw_pkg.sv
`default_nettype none

package qfkw_pkg;

    // Default size of the cell chain, in bases.
    localparam int MAX_KMER_BASES_DEFAULT = 31;

    // Fixed field widths.
    localparam int KMER_W    = 62;
    localparam int COUNT_W   = 16;
    localparam int TOTAL_W   = 24;
    localparam int KLEN_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUALITY_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOMOPOLYMER_EN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOMOPOLYMER_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KMER_LIMIT        = 3'd5;

    // Control handed from the step logic to every cell of the chain.
    typedef struct packed {
        logic              shift;
        logic              clear;
        logic [KLEN_W-1:0] k;
    } cell_ctrl_t;

    // Result of decoding one base character.
    typedef struct packed {
        logic       valid;
        logic [1:0] code;
    } base_code_t;

    function automatic base_code_t decode_base(input logic [7:0] c);
        base_code_t r;
        r.valid = 1'b1;
        unique case (c)
            8'h41, 8'h61: r.code = 2'd0;
            8'h43, 8'h63: r.code = 2'd1;
            8'h47, 8'h67: r.code = 2'd2;
            8'h54, 8'h74: r.code = 2'd3;
            default:
            begin
                r.code  = 2'd0;
                r.valid = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/qfkw_if.sv
`default_nettype none

interface qfkw_base_if;
    logic       valid;
    logic       ready;
    logic [7:0] base_char;
    logic [7:0] base_quality;
    logic       sequence_end;

    modport source (output valid, output base_char, output base_quality,
                    output sequence_end, input ready);
    modport sink   (input valid, input base_char, input base_quality,
                    input sequence_end, output ready);
endinterface

interface qfkw_kmer_if;
    logic        valid;
    logic        ready;
    logic [61:0] kmer_bits;
    logic [15:0] window_number;
    logic [15:0] position_in_window;
    logic [23:0] kmer_total;
    logic        limit_error;

    modport source (output valid, output kmer_bits, output window_number,
                    output position_in_window, output kmer_total,
                    output limit_error, input ready);
    modport sink   (input valid, input kmer_bits, input window_number,
                    input position_in_window, input kmer_total,
                    input limit_error, output ready);
endinterface

`default_nettype wire

>>> hdl/qfkw_cell.sv
`default_nettype none

// One base of the k-mer shift register. On a shift the cell takes its
// neighbor's base, or zero when it lies beyond the current k-mer length.
module qfkw_cell
    import qfkw_pkg::*;
#(
    parameter int CELL_INDEX = 0
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire logic [1:0] d,
    output logic [1:0]      shifted,
    output logic [1:0]      q
);

    logic [1:0] base_reg;
    logic [1:0] base_next;
    logic       keep;

    assign keep    = KLEN_W'(CELL_INDEX) < ctrl.k;
    assign shifted = ctrl.shift ? (keep ? d : 2'd0) : base_reg;
    assign base_next = ctrl.clear ? 2'd0 : shifted;
    assign q = base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 2'd0;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/quality_filtered_kmer_windows_unit.sv
// Channel   Direction  Payload                                          Handshake
// bases     in         base_char, base_quality, sequence_end            valid/ready
// kmers     out        kmer_bits, window_number, position_in_window,    valid/ready
//                      kmer_total, limit_error
// config    in         wr_index, wr_data                                wr_en, no wait
//
// One base is taken per cycle while the output register is free or being emptied;
// a k-mer transaction appears in the cycle after the base that causes it.
// The chain of base cells shifts all its cells in the same cycle.
// rst_n is asynchronous and active low; it loads the register defaults and clears
// all sequence state. A stalled kmers channel holds bases off only while its
// output register is full and not being taken.
`default_nettype none

`include "quality_filtered_kmer_windows_unit_assert.svh"

module quality_filtered_kmer_windows_unit
    import qfkw_pkg::*;
#(
    parameter int MAX_KMER_BASES = MAX_KMER_BASES_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    qfkw_base_if.sink                 bases,
    qfkw_kmer_if.source               kmers,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [CFG_DAT_W-1:0] wr_data
);

    // Scan phase codes. The fourth code is never entered and is read as building.
    localparam logic [1:0] PH_BUILD  = 2'd0;
    localparam logic [1:0] PH_EXTEND = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;

    localparam logic [KLEN_W-1:0] K_MAX = KLEN_W'(MAX_KMER_BASES);

    // Configuration registers.
    logic [KLEN_W-1:0]  kmer_length_reg;
    logic [6:0]         quality_threshold_reg;
    logic               homopolymer_en_reg;
    logic [7:0]         homopolymer_limit_reg;
    logic [COUNT_W-1:0] window_limit_reg;
    logic [COUNT_W-1:0] kmer_limit_reg;

    // Sequence state and its next values.
    logic [1:0]         phase_reg,          phase_next;
    logic [KLEN_W-1:0]  good_count_reg,     good_count_next;
    logic [7:0]         run_length_reg,     run_length_next;
    logic [7:0]         prev_char_reg,      prev_char_next;
    logic [7:0]         skip_char_reg,      skip_char_next;
    logic [COUNT_W-1:0] window_count_reg,   window_count_next;
    logic [COUNT_W-1:0] position_reg,       position_next;
    logic [TOTAL_W-1:0] total_reg,          total_next;
    logic               error_latched_reg,  error_latched_next;

    // Output register.
    logic               out_valid_reg,      out_valid_next;
    logic [KMER_W-1:0]  out_kmer_reg;
    logic [COUNT_W-1:0] out_window_reg,     out_window_next;
    logic [COUNT_W-1:0] out_position_reg,   out_position_next;
    logic [TOTAL_W-1:0] out_total_reg,      out_total_next;
    logic               out_error_reg,      out_error_next;
    logic [KMER_W-1:0]  out_kmer_next;

    logic               accept;
    logic               emit;
    logic [KLEN_W-1:0]  k_eff;
    base_code_t         base;
    cell_ctrl_t         cell_ctrl;
    logic               shift_now;

    // Step-local values.
    logic [1:0]         phase_eff;
    logic [KLEN_W-1:0]  good_eff;
    logic               chained;
    logic               bad;
    logic [KLEN_W-1:0]  good_inc;
    logic [COUNT_W:0]   position_inc;
    logic [TOTAL_W-1:0] total_inc;

    // Base cell chain: shifted values include this transaction's new base.
    logic [1:0]         cell_q       [MAX_KMER_BASES];
    logic [1:0]         cell_shifted [MAX_KMER_BASES];
    logic [KMER_W-1:0]  kmer_shifted;

    // A base is taken whenever the output register is free or being emptied.
    assign bases.ready = !out_valid_reg || kmers.ready;
    assign accept      = bases.valid && bases.ready;

    // A length of zero behaves as one; lengths above the chain are clamped.
    always_comb
    begin
        priority if (kmer_length_reg == '0)
        begin
            k_eff = KLEN_W'(1);
        end
        else if (kmer_length_reg > K_MAX)
        begin
            k_eff = K_MAX;
        end
        else
        begin
            k_eff = kmer_length_reg;
        end
    end

    assign base = decode_base(bases.base_char);

    assign cell_ctrl.shift = shift_now;
    assign cell_ctrl.clear = accept && bases.sequence_end;
    assign cell_ctrl.k     = k_eff;

    for (genvar i = 0; i < MAX_KMER_BASES; i++)
    begin : g_cell
        logic [1:0] cell_d;
        if (i == 0)
        begin : g_head
            assign cell_d = base.code;
        end
        else
        begin : g_link
            assign cell_d = cell_q[i-1];
        end
        qfkw_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl),
            .d       (cell_d),
            .shifted (cell_shifted[i]),
            .q       (cell_q[i])
        );
    end

    always_comb
    begin
        kmer_shifted = '0;
        for (int i = 0; i < MAX_KMER_BASES; i++)
        begin
            kmer_shifted[2*i +: 2] = cell_shifted[i];
        end
    end

    // Per-base step. The decision tree follows the order in which a base is judged:
    // the drop conditions, a skipped homopolymer run, a bad base, a homopolymer
    // break, then building or extending a window.
    always_comb
    begin
        phase_next         = phase_reg;
        good_count_next    = good_count_reg;
        run_length_next    = run_length_reg;
        prev_char_next     = prev_char_reg;
        skip_char_next     = skip_char_reg;
        window_count_next  = window_count_reg;
        position_next      = position_reg;
        total_next         = total_reg;
        error_latched_next = error_latched_reg;

        shift_now         = 1'b0;
        emit              = 1'b0;
        out_window_next   = out_window_reg;
        out_position_next = out_position_reg;
        out_total_next    = out_total_reg;
        out_error_next    = out_error_reg;

        phase_eff    = phase_reg;
        good_eff     = good_count_reg;
        chained      = 1'b0;
        bad          = 1'b0;
        good_inc     = '0;
        position_inc = '0;
        total_inc    = (total_reg == TOTAL_MAX) ? total_reg : total_reg + 1'b1;

        if (accept)
        begin
            if (!error_latched_reg && window_limit_reg != '0 && kmer_limit_reg != '0
                && !(phase_reg == PH_SKIP && bases.base_char == skip_char_reg))
            begin
                // Leaving a skipped run, or the unused code, restarts building.
                if (phase_reg == PH_SKIP)
                begin
                    phase_eff = PH_BUILD;
                    good_eff  = '0;
                end
                else if (phase_reg != PH_EXTEND && phase_reg != PH_BUILD)
                begin
                    phase_eff = PH_BUILD;
                end

                chained = (phase_eff == PH_EXTEND) || (good_eff != '0);
                if (chained && bases.base_char == prev_char_reg)
                begin
                    run_length_next = (run_length_reg == 8'hFF) ? run_length_reg
                                                                : run_length_reg + 8'd1;
                end
                else
                begin
                    run_length_next = 8'd1;
                end
                prev_char_next = bases.base_char;

                bad = !base.valid || (quality_threshold_reg != '0
                      && bases.base_quality <= {1'b0, quality_threshold_reg});

                phase_next      = phase_eff;
                good_count_next = good_eff;

                priority if (bad)
                begin
                    phase_next      = PH_BUILD;
                    good_count_next = '0;
                end
                else if (homopolymer_en_reg && run_length_next >= homopolymer_limit_reg)
                begin
                    skip_char_next  = bases.base_char;
                    phase_next      = PH_SKIP;
                    good_count_next = '0;
                end
                else if (phase_eff == PH_BUILD)
                begin
                    shift_now       = 1'b1;
                    good_inc        = good_eff + 1'b1;
                    good_count_next = good_inc;
                    if (good_inc >= k_eff)
                    begin
                        emit              = 1'b1;
                        out_window_next   = window_count_reg;
                        out_position_next = '0;
                        if (window_count_reg >= window_limit_reg)
                        begin
                            out_total_next     = total_reg;
                            out_error_next     = 1'b1;
                            error_latched_next = 1'b1;
                        end
                        else
                        begin
                            total_next        = total_inc;
                            out_total_next    = total_inc;
                            out_error_next    = 1'b0;
                            window_count_next = window_count_reg + 1'b1;
                            position_next     = '0;
                            phase_next        = PH_EXTEND;
                            good_count_next   = k_eff;
                        end
                    end
                end
                else
                begin
                    // Extending: the window number is the one opened last.
                    position_inc      = {1'b0, position_reg} + 1'b1;
                    emit              = 1'b1;
                    out_window_next   = window_count_reg - 1'b1;
                    out_position_next = position_inc[COUNT_W-1:0];
                    if (position_inc >= {1'b0, kmer_limit_reg})
                    begin
                        out_total_next     = total_reg;
                        out_error_next     = 1'b1;
                        error_latched_next = 1'b1;
                    end
                    else
                    begin
                        shift_now      = 1'b1;
                        position_next  = position_inc[COUNT_W-1:0];
                        total_next     = total_inc;
                        out_total_next = total_inc;
                        out_error_next = 1'b0;
                    end
                end
            end

            // The last base of a sequence returns all sequence state to reset.
            if (bases.sequence_end)
            begin
                phase_next         = PH_BUILD;
                good_count_next    = '0;
                run_length_next    = '0;
                prev_char_next     = '0;
                skip_char_next     = '0;
                window_count_next  = '0;
                position_next      = '0;
                total_next         = '0;
                error_latched_next = 1'b0;
            end
        end
    end

    // Error results carry no k-mer.
    assign out_kmer_next = out_error_next ? '0 : kmer_shifted;

    always_comb
    begin
        if (accept && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (kmers.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg       <= KLEN_W'(31);
            quality_threshold_reg <= '0;
            homopolymer_en_reg    <= 1'b0;
            homopolymer_limit_reg <= 8'hFF;
            window_limit_reg      <= '1;
            kmer_limit_reg        <= '1;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_KMER_LENGTH:       kmer_length_reg       <= wr_data[KLEN_W-1:0];
                REG_QUALITY_THRESHOLD: quality_threshold_reg <= wr_data[6:0];
                REG_HOMOPOLYMER_EN:    homopolymer_en_reg    <= wr_data[0];
                REG_HOMOPOLYMER_LIMIT: homopolymer_limit_reg <= wr_data[7:0];
                REG_WINDOW_LIMIT:      window_limit_reg      <= wr_data;
                REG_KMER_LIMIT:        kmer_limit_reg        <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_BUILD;
            good_count_reg    <= '0;
            run_length_reg    <= '0;
            prev_char_reg     <= '0;
            skip_char_reg     <= '0;
            window_count_reg  <= '0;
            position_reg      <= '0;
            total_reg         <= '0;
            error_latched_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            good_count_reg    <= good_count_next;
            run_length_reg    <= run_length_next;
            prev_char_reg     <= prev_char_next;
            skip_char_reg     <= skip_char_next;
            window_count_reg  <= window_count_next;
            position_reg      <= position_next;
            total_reg         <= total_next;
            error_latched_reg <= error_latched_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Result payload is loaded only with a new transaction.
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_kmer_reg     <= out_kmer_next;
            out_window_reg   <= out_window_next;
            out_position_reg <= out_position_next;
            out_total_reg    <= out_total_next;
            out_error_reg    <= out_error_next;
        end
    end

    assign kmers.valid              = out_valid_reg;
    assign kmers.kmer_bits          = out_kmer_reg;
    assign kmers.window_number      = out_window_reg;
    assign kmers.position_in_window = out_position_reg;
    assign kmers.kmer_total         = out_total_reg;
    assign kmers.limit_error        = out_error_reg;

    // The end of a sequence leaves the scanner empty and free of errors.
    `QFKW_ASSERT_NEXT(a_seq_end_clears, accept && bases.sequence_end, phase_reg == PH_BUILD && window_count_reg == '0 && !error_latched_reg, "sequence end did not clear state")
    // An error result within a sequence latches the error.
    `QFKW_ASSERT_NEXT(a_error_latches, accept && emit && out_error_next && !bases.sequence_end, error_latched_reg, "limit error not latched")
    // While a window is open at least one window has been counted.
    `QFKW_ASSERT_SAME(a_extend_has_window, phase_reg == PH_EXTEND, window_count_reg != '0, "open window with zero window count")
    // Once latched, an error stops results until the sequence ends.
    `QFKW_ASSERT_SAME(a_error_silences, accept && error_latched_reg, !emit, "result produced after limit error")

endmodule

`default_nettype wire
